// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the integer flag unit. Each macro
// samples on the rising edge of clk and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When ante holds at an edge, cons must hold at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// When ante holds at an edge, cons must hold at the same edge.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: sv/pif_pkg.sv
// ----------------------------------------------------------------------------
// pif_pkg
// Types and constants shared by the integer flag unit modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pif_pkg;

  localparam int unsigned WordW = 32;

  localparam logic [WordW-1:0] SIGN_BIT   = 32'h8000_0000;
  localparam logic [WordW-1:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [5:0]       SHIFT_BIG  = 6'h20;

  typedef enum logic [3:0] {
    ACT_ADD    = 4'd0,
    ACT_ADDE   = 4'd1,
    ACT_ADDME  = 4'd2,
    ACT_ADDZE  = 4'd3,
    ACT_DIVW   = 4'd4,
    ACT_DIVWU  = 4'd5,
    ACT_MULLW  = 4'd6,
    ACT_NEG    = 4'd7,
    ACT_SUBF   = 4'd8,
    ACT_SUBFC  = 4'd9,
    ACT_SUBFE  = 4'd10,
    ACT_SUBFME = 4'd11,
    ACT_SUBFZE = 4'd12,
    ACT_SUBFI  = 4'd13,
    ACT_SRAW   = 4'd14,
    ACT_SRAWI  = 4'd15
  } action_t;

  // Flag bundle handed from the evaluation logic to the pipeline.
  typedef struct packed {
    logic       ov;
    logic       ovd;
    logic       ca;
    logic       cad;
    logic [3:0] cond;
  } flags_t;

endpackage

// File: sv/pif_flags.sv
// ----------------------------------------------------------------------------
// pif_flags
// Overflow, carry and condition evaluation for every operation except the
// multiply overflow test, which the pipeline finishes later.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pif_flags (
  input  logic [3:0]              action,
  input  logic [31:0]             result_word,
  input  logic [31:0]             operand_a,
  input  logic [31:0]             operand_b,
  input  logic                    carry_in,
  input  logic                    summary_overflow,
  input  logic                    condition_copy,
  output pif_pkg::flags_t         flags
);
  import pif_pkg::*;

  logic [31:0] na;
  logic        ov_add;
  logic        ov_sub;
  logic        r_lt_a;
  logic        r_eq_a;
  logic        r_le_b;
  logic        r_lt_b;
  logic [4:0]  sh_amt;
  logic [31:0] lost_mask;
  logic        sh_carry;

  assign na     = ~operand_a;
  assign ov_add = ~(operand_a[31] ^ operand_b[31]) & (operand_a[31] ^ result_word[31]);
  assign ov_sub = ~(na[31] ^ operand_b[31]) & (na[31] ^ result_word[31]);
  assign r_lt_a = result_word < operand_a;
  assign r_eq_a = result_word == operand_a;
  assign r_lt_b = result_word < operand_b;
  assign r_le_b = result_word <= operand_b;

  // The bits shifted out are the low sh_amt bits of the operand.
  assign sh_amt    = operand_b[4:0];
  assign lost_mask = ~(ALL_ONES << sh_amt);
  assign sh_carry  = (sh_amt != 5'd0) && operand_a[31] && ((operand_a & lost_mask) != '0);

  always_comb begin
    flags.ov  = 1'b0;
    flags.ovd = 1'b1;
    flags.ca  = 1'b0;
    flags.cad = 1'b1;
    unique case (action_t'(action))
      ACT_ADD: begin
        flags.ov = ov_add;
        flags.ca = r_lt_a;
      end
      ACT_ADDE: begin
        flags.ov = ov_add;
        flags.ca = r_lt_a || (carry_in && r_eq_a);
      end
      ACT_ADDME: begin
        flags.ov = operand_a[31] & (operand_a[31] ^ result_word[31]);
        flags.ca = operand_a != '0;
      end
      ACT_ADDZE: begin
        flags.ov = na[31] & (operand_a[31] ^ result_word[31]);
        flags.ca = r_lt_a;
      end
      ACT_DIVW: begin
        flags.ov  = (operand_a == SIGN_BIT && operand_b == ALL_ONES) || operand_b == '0;
        flags.cad = 1'b0;
      end
      ACT_DIVWU: begin
        flags.ov  = operand_b == '0;
        flags.cad = 1'b0;
      end
      ACT_MULLW: begin
        // Overflow is settled from the product further down the pipeline.
        flags.cad = 1'b0;
      end
      ACT_NEG: begin
        flags.ov  = operand_a == SIGN_BIT;
        flags.cad = 1'b0;
      end
      ACT_SUBF: begin
        flags.ov  = ov_sub;
        flags.cad = 1'b0;
      end
      ACT_SUBFC: begin
        flags.ov = ov_sub;
        flags.ca = r_le_b;
      end
      ACT_SUBFE: begin
        flags.ov = ov_sub;
        flags.ca = r_lt_b || (carry_in && result_word == operand_b);
      end
      ACT_SUBFME: begin
        flags.ov = na[31] & (na[31] ^ result_word[31]);
        flags.ca = result_word != ALL_ONES;
      end
      ACT_SUBFZE: begin
        flags.ov = operand_a[31] & (na[31] ^ result_word[31]);
        flags.ca = r_le_b;
      end
      ACT_SUBFI: begin
        flags.ovd = 1'b0;
        flags.ca  = r_le_b;
      end
      ACT_SRAW: begin
        flags.ovd = 1'b0;
        // A shift of 32 or more carries whenever the operand is negative.
        flags.ca  = ((operand_b[5:0] & SHIFT_BIG) != '0) ? operand_a[31] : sh_carry;
      end
      default: begin
        flags.ovd = 1'b0;
        flags.ca  = sh_carry;
      end
    endcase

    if (condition_copy) begin
      flags.cond = result_word[31:28];
    end else begin
      flags.cond = {result_word[31],
                    !result_word[31] && (result_word != '0),
                    result_word == '0,
                    summary_overflow};
    end
  end

endmodule

// File: sv/ppc32_integer_flag_unit_core.sv
// ----------------------------------------------------------------------------
// ppc32_integer_flag_unit_core
// XER overflow and carry plus CR field evaluation for 32-bit integer
// operations: a three-stage pipeline, one request per cycle unless stalled.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------
//  request | in_valid / in_ready  | action, result_word, operand_a, operand_b,
//          |                      | carry_in, summary_overflow, condition_copy
//  result  | out_valid / out_ready| overflow_flag, overflow_defined,
//          |                      | carry_flag, carry_defined, condition_field
//
//  out_valid rises once a request has passed through stages one, two and
//  three. Throughput is one request per cycle, since every stage hands on
//  its contents each cycle it is not stalled; the 32x32 signed multiplier
//  makes stage two the deepest.
//  Stage one evaluates all flags but the multiply overflow, stage two forms
//  the product, stage three tests whether it fits in 32 signed bits.
//  rst is synchronous and clears only the stage valid bits.
//  A stall on out_ready backs up stage by stage; a stage takes new data
//  whenever it is empty or its successor is taking its contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppc32_integer_flag_unit_core (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  action,
  input  logic [31:0] result_word,
  input  logic [31:0] operand_a,
  input  logic [31:0] operand_b,
  input  logic        carry_in,
  input  logic        summary_overflow,
  input  logic        condition_copy,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        overflow_flag,
  output logic        overflow_defined,
  output logic        carry_flag,
  output logic        carry_defined,
  output logic [3:0]  condition_field
);
  import pif_pkg::*;

  // Combinational flag evaluation feeding stage one.
  flags_t      eval_flags;

  // Stage one: flags plus the multiply operands.
  logic        v1;
  flags_t      flags1;
  logic        mul1;
  logic [31:0] a1;
  logic [31:0] b1;

  // Stage two: flags plus the 64-bit signed product.
  logic        v2;
  flags_t      flags2;
  logic        mul2;
  logic [63:0] prod2;

  // Stage three: final result register.
  logic        v3;
  flags_t      flags3;
  flags_t      flags3_next;

  logic        rdy1;
  logic        rdy2;
  logic        rdy3;
  logic        mul_ovf;

  pif_flags u_flags (
    .action           (action),
    .result_word      (result_word),
    .operand_a        (operand_a),
    .operand_b        (operand_b),
    .carry_in         (carry_in),
    .summary_overflow (summary_overflow),
    .condition_copy   (condition_copy),
    .flags            (eval_flags)
  );

  // Each stage can load when it is empty or is being drained downstream.
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Control: valid bits follow their data through the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  // Stage one payload.
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      flags1 <= eval_flags;
      mul1   <= action_t'(action) == ACT_MULLW;
      a1     <= operand_a;
      b1     <= operand_b;
    end
  end

  // Stage two payload: the signed product of the two operands.
  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      flags2 <= flags1;
      mul2   <= mul1;
      prod2  <= 64'($signed(a1) * $signed(b1));
    end
  end

  // The product fits when its upper 33 bits are all copies of the sign.
  assign mul_ovf = (prod2[63:31] != '0) && (prod2[63:31] != '1);

  // Fold in the multiply overflow before stage three.
  always_comb begin
    flags3_next = flags2;
    if (mul2) begin
      flags3_next.ov = mul_ovf;
    end
  end

  // Stage three payload.
  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      flags3 <= flags3_next;
    end
  end

  assign out_valid        = v3;
  assign overflow_flag    = flags3.ov;
  assign overflow_defined = flags3.ovd;
  assign carry_flag       = flags3.ca;
  assign carry_defined    = flags3.cad;
  assign condition_field  = flags3.cond;

  // An accepted request always lands in stage one.
  `ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, v1, "accepted request lost at stage one")
  // A full stage two with room downstream must advance into stage three.
  `ASSERT_NEXT(a_s2_advances, v2 && rdy3, v3, "stage two contents did not advance")
  // Operations without an overflow rule never report overflow.
  `ASSERT_SAME(a_ov_rule, out_valid && !overflow_defined, !overflow_flag,
               "overflow set without an overflow rule")
  // Operations without a carry rule never report carry.
  `ASSERT_SAME(a_ca_rule, out_valid && !carry_defined, !carry_flag,
               "carry set without a carry rule")

endmodule
